// ===== rtl/civ_frame_radio_responder_macros.svh =====
// ---------------------------------------------------------------------------
// civ_frame_radio_responder_macros.svh
// assertion macros shared by the responder rtl
// ---------------------------------------------------------------------------
`ifndef CIV_FRAME_RADIO_RESPONDER_MACROS_SVH
`define CIV_FRAME_RADIO_RESPONDER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CIV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CIV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CIV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CIV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/civ_pkg.sv =====
// ---------------------------------------------------------------------------
// civ_pkg
// types and constants of the radio control frame responder
// ---------------------------------------------------------------------------
`default_nettype none

package civ_pkg;

  // frame bytes
  localparam logic [7:0] PREAMBLE   = 8'hFE;
  localparam logic [7:0] TERMINATOR = 8'hFD;

  // radio state after reset
  localparam logic [31:0] FREQ_RESET    = 32'd145000000;
  localparam logic [7:0]  MODE_RESET    = 8'd1;
  localparam logic [7:0]  SQUELCH_RESET = 8'd1;

  // input item commands
  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_POLL   = 2'd1;
  localparam logic [1:0] CMD_PRESET = 2'd2;

  // result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  // change codes
  localparam logic [1:0] CHG_NONE    = 2'd0;
  localparam logic [1:0] CHG_FREQ    = 2'd1;
  localparam logic [1:0] CHG_MODE    = 2'd2;
  localparam logic [1:0] CHG_SQUELCH = 2'd3;

  // configuration register indexes
  localparam int unsigned APB_ADDR_W = 5;
  localparam logic [2:0] REG_SET_FREQ    = 3'd0;
  localparam logic [2:0] REG_GET_FREQ    = 3'd1;
  localparam logic [2:0] REG_SET_SQUELCH = 3'd2;
  localparam logic [2:0] REG_GET_SQUELCH = 3'd3;
  localparam logic [2:0] REG_SET_MODE    = 3'd4;

  // command code reset values
  localparam logic [7:0] SET_FREQ_RESET    = 8'd5;
  localparam logic [7:0] GET_FREQ_RESET    = 8'd3;
  localparam logic [7:0] SET_SQUELCH_RESET = 8'd20;
  localparam logic [7:0] GET_SQUELCH_RESET = 8'd21;
  localparam logic [7:0] SET_MODE_RESET    = 8'd6;

  // frequency word and its decimal form
  localparam int unsigned FREQ_W     = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;

  // byte positions in a reply frame
  localparam logic [3:0] POS_FROM_ADDR     = 4'd2;
  localparam logic [3:0] POS_TO_ADDR       = 4'd3;
  localparam logic [3:0] POS_CODE          = 4'd4;
  localparam logic [3:0] POS_DATA          = 4'd5;
  localparam logic [3:0] POS_LAST_FREQ     = 4'd10;
  localparam logic [3:0] POS_LAST_SQUELCH  = 4'd6;

  typedef struct packed {
    logic [7:0] set_freq;
    logic [7:0] get_freq;
    logic [7:0] set_squelch;
    logic [7:0] get_squelch;
    logic [7:0] set_mode;
  } codes_t;

  // captured header and data of the last finished frame
  typedef struct packed {
    logic            has_one;
    logic            has_five;
    logic [7:0]      to_addr;
    logic [7:0]      from_addr;
    logic [7:0]      code;
    logic [4:0][7:0] data;
  } frame_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_CONVERT,
    ST_SEND,
    ST_POLL
  } state_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SET_FREQ,
    ACT_GET_FREQ,
    ACT_SET_SQUELCH,
    ACT_GET_SQUELCH,
    ACT_SET_MODE
  } action_e;

  typedef enum logic {
    RPL_FREQ,
    RPL_SQUELCH
  } reply_e;

endpackage

`default_nettype wire

// ===== rtl/civ_apb_regs.sv =====
// ---------------------------------------------------------------------------
// civ_apb_regs
// apb register file holding the five command code bytes
// ---------------------------------------------------------------------------
`default_nettype none

module civ_apb_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [civ_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output civ_pkg::codes_t                      codes_o
);

  civ_pkg::codes_t codes_q;
  logic [2:0]      reg_idx;
  logic            wr_en;
  logic [7:0]      rd_byte;

  assign reg_idx = paddr[civ_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.set_freq    <= civ_pkg::SET_FREQ_RESET;
      codes_q.get_freq    <= civ_pkg::GET_FREQ_RESET;
      codes_q.set_squelch <= civ_pkg::SET_SQUELCH_RESET;
      codes_q.get_squelch <= civ_pkg::GET_SQUELCH_RESET;
      codes_q.set_mode    <= civ_pkg::SET_MODE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        civ_pkg::REG_SET_FREQ:    codes_q.set_freq    <= pwdata[7:0];
        civ_pkg::REG_GET_FREQ:    codes_q.get_freq    <= pwdata[7:0];
        civ_pkg::REG_SET_SQUELCH: codes_q.set_squelch <= pwdata[7:0];
        civ_pkg::REG_GET_SQUELCH: codes_q.get_squelch <= pwdata[7:0];
        civ_pkg::REG_SET_MODE:    codes_q.set_mode    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      civ_pkg::REG_SET_FREQ:    rd_byte = codes_q.set_freq;
      civ_pkg::REG_GET_FREQ:    rd_byte = codes_q.get_freq;
      civ_pkg::REG_SET_SQUELCH: rd_byte = codes_q.set_squelch;
      civ_pkg::REG_GET_SQUELCH: rd_byte = codes_q.get_squelch;
      civ_pkg::REG_SET_MODE:    rd_byte = codes_q.set_mode;
      default:                  rd_byte = 8'h00;
    endcase
  end

  assign prdata  = {24'h000000, rd_byte};
  assign codes_o = codes_q;

endmodule

`default_nettype wire

// ===== rtl/civ_frame_rx.sv =====
// ---------------------------------------------------------------------------
// civ_frame_rx
// frame collector: fill count, preamble restart, terminator detection
// ---------------------------------------------------------------------------
`default_nettype none

module civ_frame_rx #(
  parameter int unsigned FRAME_DEPTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       byte_valid_i,
  input  wire logic [7:0] byte_i,
  output logic            act_o,
  output civ_pkg::frame_t frame_o
);

  localparam int unsigned FILL_W = $clog2(FRAME_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX     = FILL_W'(FRAME_DEPTH);
  localparam logic [FILL_W-1:0] FILL_ONE     = FILL_W'(1);
  localparam logic [FILL_W-1:0] FILL_RESTART = FILL_W'(2);
  localparam logic [FILL_W-1:0] FILL_FRAME   = FILL_W'(6);
  localparam logic [FILL_W-1:0] FILL_DATA1   = FILL_W'(7);
  localparam logic [FILL_W-1:0] FILL_DATA5   = FILL_W'(11);

  logic [FILL_W-1:0] fill_q, fill_d, fill_inc, fill_rst;
  // the two most recently stored bytes stand in for the store tail
  logic [7:0]        prev1_q, prev2_q, prev1_d, prev2_d;
  // only offsets 2 to 9 are ever read back
  logic [7:0]        cap_q [2:9];
  logic              has_one_q, has_five_q;
  logic              stored, restart, term;

  always_comb begin
    stored   = fill_q < FILL_MAX;
    fill_inc = stored ? fill_q + FILL_ONE : fill_q;
    prev1_d  = stored ? byte_i  : prev1_q;
    prev2_d  = stored ? prev1_q : prev2_q;
    restart  = (fill_inc >= FILL_RESTART) && (prev1_d == civ_pkg::PREAMBLE) &&
               (prev2_d == civ_pkg::PREAMBLE);
    fill_rst = restart ? FILL_RESTART : fill_inc;
    term     = byte_i == civ_pkg::TERMINATOR;
    fill_d   = term ? '0 : fill_rst;
    act_o    = byte_valid_i && term && (fill_rst >= FILL_FRAME);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (byte_valid_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_valid_i) begin
      prev1_q <= prev1_d;
      prev2_q <= prev2_d;
      for (int i = 2; i <= 9; i++) begin
        if (stored && (fill_q == FILL_W'(i))) begin
          cap_q[i] <= byte_i;
        end
      end
    end
    if (act_o) begin
      has_one_q  <= fill_rst >= FILL_DATA1;
      has_five_q <= fill_rst >= FILL_DATA5;
    end
  end

  always_comb begin
    frame_o.has_one   = has_one_q;
    frame_o.has_five  = has_five_q;
    frame_o.to_addr   = cap_q[2];
    frame_o.from_addr = cap_q[3];
    frame_o.code      = cap_q[4];
    for (int k = 0; k < 5; k++) begin
      frame_o.data[k] = cap_q[5 + k];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/civ_bcd2bin.sv =====
// ---------------------------------------------------------------------------
// civ_bcd2bin
// digit-serial decimal to binary, one digit per cycle, modulo 2^32
// ---------------------------------------------------------------------------
`default_nettype none

module civ_bcd2bin (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [civ_pkg::BCD_W-1:0]     digits_i,
  output logic                               done_o,
  output logic      [civ_pkg::FREQ_W-1:0]    value_o
);

  localparam logic [3:0] CNT_LAST = 4'(civ_pkg::BCD_DIGITS - 1);

  logic                        busy_q, done_q;
  logic [3:0]                  cnt_q;
  logic [civ_pkg::BCD_W-1:0]   sr_q;
  logic [civ_pkg::FREQ_W-1:0]  acc_q, acc_d;
  logic                        last_step;

  assign last_step = busy_q && (cnt_q == CNT_LAST);

  // acc * 10 + digit, nibbles above nine taken as they are
  assign acc_d = {acc_q[civ_pkg::FREQ_W-4:0], 3'b000} +
                 {acc_q[civ_pkg::FREQ_W-2:0], 1'b0} +
                 civ_pkg::FREQ_W'(sr_q[civ_pkg::BCD_W-1 -: 4]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sr_q  <= digits_i;
      acc_q <= '0;
    end else if (busy_q) begin
      sr_q  <= {sr_q[civ_pkg::BCD_W-5:0], 4'h0};
      acc_q <= acc_d;
    end
  end

  assign done_o  = done_q;
  assign value_o = acc_q;

endmodule

`default_nettype wire

// ===== rtl/civ_bin2bcd.sv =====
// ---------------------------------------------------------------------------
// civ_bin2bcd
// bit-serial binary to decimal (shift and add three), one bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module civ_bin2bcd (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [civ_pkg::FREQ_W-1:0]    value_i,
  output logic                               done_o,
  output logic      [civ_pkg::BCD_W-1:0]     bcd_o
);

  localparam int unsigned CNT_W = $clog2(civ_pkg::FREQ_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(civ_pkg::FREQ_W - 1);

  logic                        busy_q, done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [civ_pkg::FREQ_W-1:0]  bin_q;
  logic [civ_pkg::BCD_W-1:0]   bcd_q, adj;
  logic                        last_step;

  assign last_step = busy_q && (cnt_q == CNT_LAST);

  always_comb begin
    for (int k = 0; k < civ_pkg::BCD_DIGITS; k++) begin
      adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
                                                : bcd_q[4*k +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[civ_pkg::FREQ_W-2:0], 1'b0};
      bcd_q <= {adj[civ_pkg::BCD_W-2:0], bin_q[civ_pkg::FREQ_W-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

// ===== rtl/civ_frame_radio_responder.sv =====
// ---------------------------------------------------------------------------
// civ_frame_radio_responder
// radio control frame responder: collects serial frame bytes, acts on
// finished frames (set/get frequency, set/get squelch, set mode), sends
// reply frames byte by byte and answers change polls
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------
//  input    | in        | in_valid_i / in_stall_o | cmd, rx_byte, preset_*
//  output   | out       | out_valid_o/out_stall_i | out_kind, tx_byte, last,..
//  config   | in/out    | apb psel/penable/pready | five command code bytes
//
//  a received byte that ends no frame, a preset and the unused command value
//  finish on acceptance; a finished frame goes to decode, where an unknown
//  code, too little data, set squelch and set mode end; a poll waits in the
//  poll state until the output is free; set frequency: accept, decode, the
//  one-digit-per-cycle decimal decoder and a load step; get frequency and
//  get squelch: accept, decode (get frequency then runs the bit-serial
//  encoder and a handoff), one reply byte per cycle unless the output stalls
//  one item is in work at a time; the output register lets the next item
//  in while the final result still waits for transfer
//  reset clears fill count and change flags, sets the radio state to its reset values; no sweep
//  a stalled output holds the reply sequencer on the current byte
// ---------------------------------------------------------------------------
`default_nettype none

`include "civ_frame_radio_responder_macros.svh"

module civ_frame_radio_responder #(
  parameter int unsigned FRAME_DEPTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     cmd_i,
  input  wire logic [7:0]                     rx_byte_i,
  input  wire logic [31:0]                    preset_frequency_i,
  input  wire logic [7:0]                     preset_mode_i,
  input  wire logic [7:0]                     preset_squelch_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                out_kind_o,
  output logic      [7:0]                     tx_byte_o,
  output logic                                last_o,
  output logic      [1:0]                     change_code_o,
  output logic      [31:0]                    cur_frequency_o,
  output logic      [7:0]                     cur_mode_o,
  output logic      [7:0]                     cur_squelch_o,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [civ_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);

  civ_pkg::state_e  state_q, state_d;
  civ_pkg::action_e action;
  civ_pkg::reply_e  reply_q, reply_d;
  civ_pkg::codes_t  codes;
  civ_pkg::frame_t  frame;

  logic        in_accept, out_free, frame_act;
  // control strobes
  logic        byte_valid, preset_ld, b2b_start, bcd_start, freq_ld;
  logic        squelch_ld, mode_ld, reply_ld, send_ld, poll_ld;

  logic [3:0]  idx_q;
  logic [31:0] freq_q;
  logic [7:0]  mode_q, squelch_q;
  logic        freq_chg_q, mode_chg_q, squelch_chg_q;
  logic [1:0]  chg;

  logic [civ_pkg::BCD_W-1:0]  digits, bcd;
  logic [4:0][7:0]            bcd_bytes;
  logic [2:0]                 data_sel;
  logic [31:0]                b2b_value;
  logic                       b2b_done, bcd_done;
  logic [7:0]                 reply_byte;
  logic                       send_last;

  logic        out_valid_q, out_kind_q, out_last_q;
  logic [7:0]  out_tx_q, out_mode_q, out_squelch_q;
  logic [1:0]  out_chg_q;
  logic [31:0] out_freq_q;

  // ------------------------------------------------------------------
  // submodules
  // ------------------------------------------------------------------
  civ_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .codes_o (codes)
  );

  civ_frame_rx #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_i       (rx_byte_i),
    .act_o        (frame_act),
    .frame_o      (frame)
  );

  // digits go in most significant first: last data byte, low nibble leads
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      digits[8*k +: 8] = {frame.data[k][3:0], frame.data[k][7:4]};
    end
  end

  civ_bcd2bin u_bcd2bin (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (b2b_start),
    .digits_i (digits),
    .done_o   (b2b_done),
    .value_o  (b2b_value)
  );

  civ_bin2bcd u_bin2bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .value_i (freq_q),
    .done_o  (bcd_done),
    .bcd_o   (bcd)
  );

  // ------------------------------------------------------------------
  // handshakes
  // ------------------------------------------------------------------
  assign in_stall_o = state_q != civ_pkg::ST_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // command decode, first match wins; set commands short of data do nothing
  always_comb begin
    if (frame.code == codes.set_freq) begin
      action = frame.has_five ? civ_pkg::ACT_SET_FREQ : civ_pkg::ACT_NONE;
    end else if (frame.code == codes.get_freq) begin
      action = civ_pkg::ACT_GET_FREQ;
    end else if (frame.code == codes.set_squelch) begin
      action = frame.has_one ? civ_pkg::ACT_SET_SQUELCH : civ_pkg::ACT_NONE;
    end else if (frame.code == codes.get_squelch) begin
      action = civ_pkg::ACT_GET_SQUELCH;
    end else if (frame.code == codes.set_mode) begin
      action = frame.has_one ? civ_pkg::ACT_SET_MODE : civ_pkg::ACT_NONE;
    end else begin
      action = civ_pkg::ACT_NONE;
    end
  end

  // ------------------------------------------------------------------
  // reply byte selection
  // ------------------------------------------------------------------
  assign bcd_bytes = bcd;
  assign data_sel  = 3'(idx_q - civ_pkg::POS_DATA);

  always_comb begin
    if (idx_q < civ_pkg::POS_FROM_ADDR) begin
      reply_byte = civ_pkg::PREAMBLE;
    end else if (idx_q == civ_pkg::POS_FROM_ADDR) begin
      reply_byte = frame.from_addr;
    end else if (idx_q == civ_pkg::POS_TO_ADDR) begin
      reply_byte = frame.to_addr;
    end else if (idx_q == civ_pkg::POS_CODE) begin
      reply_byte = (reply_q == civ_pkg::RPL_FREQ) ? codes.get_freq : codes.get_squelch;
    end else if (reply_q == civ_pkg::RPL_FREQ) begin
      // first data byte carries the two most significant digits
      reply_byte = (idx_q < civ_pkg::POS_LAST_FREQ) ? bcd_bytes[3'd4 - data_sel]
                                                     : civ_pkg::TERMINATOR;
    end else begin
      reply_byte = (idx_q == civ_pkg::POS_DATA) ? squelch_q : civ_pkg::TERMINATOR;
    end
    send_last = idx_q == ((reply_q == civ_pkg::RPL_FREQ) ? civ_pkg::POS_LAST_FREQ
                                                          : civ_pkg::POS_LAST_SQUELCH);
  end

  // poll priority: frequency, mode, squelch
  always_comb begin
    if (freq_chg_q) begin
      chg = civ_pkg::CHG_FREQ;
    end else if (mode_chg_q) begin
      chg = civ_pkg::CHG_MODE;
    end else if (squelch_chg_q) begin
      chg = civ_pkg::CHG_SQUELCH;
    end else begin
      chg = civ_pkg::CHG_NONE;
    end
  end

  // ------------------------------------------------------------------
  // sequencer: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      civ_pkg::ST_IDLE: begin
        if (in_accept && (cmd_i == civ_pkg::CMD_BYTE) && frame_act) begin
          state_d = civ_pkg::ST_DECODE;
        end else if (in_accept && (cmd_i == civ_pkg::CMD_POLL)) begin
          state_d = civ_pkg::ST_POLL;
        end
      end
      civ_pkg::ST_DECODE: begin
        case (action)
          civ_pkg::ACT_SET_FREQ:    state_d = civ_pkg::ST_LOAD;
          civ_pkg::ACT_GET_FREQ:    state_d = civ_pkg::ST_CONVERT;
          civ_pkg::ACT_GET_SQUELCH: state_d = civ_pkg::ST_SEND;
          default:                  state_d = civ_pkg::ST_IDLE;
        endcase
      end
      civ_pkg::ST_LOAD: begin
        if (b2b_done) begin
          state_d = civ_pkg::ST_IDLE;
        end
      end
      civ_pkg::ST_CONVERT: begin
        if (bcd_done) begin
          state_d = civ_pkg::ST_SEND;
        end
      end
      civ_pkg::ST_SEND: begin
        if (out_free && send_last) begin
          state_d = civ_pkg::ST_IDLE;
        end
      end
      civ_pkg::ST_POLL: begin
        if (out_free) begin
          state_d = civ_pkg::ST_IDLE;
        end
      end
      default: state_d = civ_pkg::ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // sequencer: control strobes
  // ------------------------------------------------------------------
  always_comb begin
    byte_valid = 1'b0;
    preset_ld  = 1'b0;
    b2b_start  = 1'b0;
    bcd_start  = 1'b0;
    freq_ld    = 1'b0;
    squelch_ld = 1'b0;
    mode_ld    = 1'b0;
    reply_ld   = 1'b0;
    reply_d    = reply_q;
    send_ld    = 1'b0;
    poll_ld    = 1'b0;
    case (state_q)
      civ_pkg::ST_IDLE: begin
        byte_valid = in_accept && (cmd_i == civ_pkg::CMD_BYTE);
        preset_ld  = in_accept && (cmd_i == civ_pkg::CMD_PRESET);
      end
      civ_pkg::ST_DECODE: begin
        reply_ld = 1'b1;
        case (action)
          civ_pkg::ACT_SET_FREQ:    b2b_start  = 1'b1;
          civ_pkg::ACT_GET_FREQ: begin
            bcd_start = 1'b1;
            reply_d   = civ_pkg::RPL_FREQ;
          end
          civ_pkg::ACT_SET_SQUELCH: squelch_ld = 1'b1;
          civ_pkg::ACT_GET_SQUELCH: reply_d    = civ_pkg::RPL_SQUELCH;
          civ_pkg::ACT_SET_MODE:    mode_ld    = 1'b1;
          default: ;
        endcase
      end
      civ_pkg::ST_LOAD:  freq_ld = b2b_done;
      civ_pkg::ST_SEND:  send_ld = out_free;
      civ_pkg::ST_POLL:  poll_ld = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= civ_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // reply kind and byte position
  always_ff @(posedge clk_i) begin
    if (reply_ld) begin
      reply_q <= reply_d;
      idx_q   <= '0;
    end else if (send_ld) begin
      idx_q <= idx_q + 4'd1;
    end
  end

  // ------------------------------------------------------------------
  // radio state and change flags
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q        <= civ_pkg::FREQ_RESET;
      mode_q        <= civ_pkg::MODE_RESET;
      squelch_q     <= civ_pkg::SQUELCH_RESET;
      freq_chg_q    <= 1'b0;
      mode_chg_q    <= 1'b0;
      squelch_chg_q <= 1'b0;
    end else begin
      // preset leaves the change flags alone
      if (preset_ld) begin
        freq_q    <= preset_frequency_i;
        mode_q    <= preset_mode_i;
        squelch_q <= preset_squelch_i;
      end
      if (freq_ld) begin
        freq_q     <= b2b_value;
        freq_chg_q <= 1'b1;
      end
      if (squelch_ld) begin
        squelch_q     <= frame.data[0];
        squelch_chg_q <= 1'b1;
      end
      if (mode_ld) begin
        mode_q     <= frame.data[0];
        mode_chg_q <= 1'b1;
      end
      // one flag cleared per poll
      if (poll_ld) begin
        case (chg)
          civ_pkg::CHG_FREQ:    freq_chg_q    <= 1'b0;
          civ_pkg::CHG_MODE:    mode_chg_q    <= 1'b0;
          civ_pkg::CHG_SQUELCH: squelch_chg_q <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // ------------------------------------------------------------------
  // output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (send_ld || poll_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (send_ld) begin
      out_kind_q    <= civ_pkg::KIND_BYTE;
      out_tx_q      <= reply_byte;
      out_last_q    <= send_last;
      out_chg_q     <= civ_pkg::CHG_NONE;
      out_freq_q    <= '0;
      out_mode_q    <= '0;
      out_squelch_q <= '0;
    end else if (poll_ld) begin
      out_kind_q    <= civ_pkg::KIND_POLL;
      out_tx_q      <= '0;
      out_last_q    <= 1'b1;
      out_chg_q     <= chg;
      out_freq_q    <= freq_q;
      out_mode_q    <= mode_q;
      out_squelch_q <= squelch_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = out_kind_q;
  assign tx_byte_o       = out_tx_q;
  assign last_o          = out_last_q;
  assign change_code_o   = out_chg_q;
  assign cur_frequency_o = out_freq_q;
  assign cur_mode_o      = out_mode_q;
  assign cur_squelch_o   = out_squelch_q;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  `CIV_ASSERT_NXT(a_poll_enters_poll, clk_i, rst_ni,
                  in_accept && (cmd_i == civ_pkg::CMD_POLL), state_q == civ_pkg::ST_POLL)
  `CIV_ASSERT_IMP(a_poll_answer_shape, clk_i, rst_ni,
                  out_valid_o && (out_kind_o == civ_pkg::KIND_POLL),
                  last_o && (tx_byte_o == 8'h00))
  `CIV_ASSERT_IMP(a_encoder_done_in_convert, clk_i, rst_ni,
                  bcd_done, state_q == civ_pkg::ST_CONVERT)
  `CIV_ASSERT_NXT(a_last_byte_frees_input, clk_i, rst_ni,
                  send_ld && send_last, state_q == civ_pkg::ST_IDLE)

endmodule

`default_nettype wire

// ===== tb/tb_civ_frame_radio_responder.sv =====
// ---------------------------------------------------------------------------
// tb_civ_frame_radio_responder
// self-checking bench for the radio control frame responder
//
// a queue of pending items feeds a clocked driver on the input channel; a
// clocked monitor on the output channel compares every result transfer
// field by field against responses predicted from a bench-side copy of the
// frame store, radio state, change flags and command codes. a short
// directed run is followed by four random phases with different command
// codes and idle patterns, one of which holds the output off for a long
// stretch so that the block backs up into its input
// ---------------------------------------------------------------------------
`default_nettype none

module tb_civ_frame_radio_responder;
  timeunit 1ns;
  timeprecision 1ps;

  import civ_pkg::*;

  localparam int unsigned DEPTH        = 32;
  localparam int unsigned LIMIT        = 400000;  // whole-run cycle budget
  localparam int unsigned DRAIN_LIMIT  = 8000;    // wait for owed responses
  localparam int unsigned TAIL_CYCLES  = 64;      // set frequency gives no result
  localparam int unsigned HOLD_CYCLES  = 400;     // long output hold-off
  localparam int unsigned PHASE_ITEMS  = 95;

  // unused command value, must be ignored
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // frame shapes for the random stream
  localparam int unsigned SHAPE_WHOLE     = 0;
  localparam int unsigned SHAPE_TRUNCATED = 1;
  localparam int unsigned SHAPE_OVERFLOW  = 2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic [31:0] preset_frequency;
    logic [7:0]  preset_mode;
    logic [7:0]  preset_squelch;
  } radio_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  change_code;
    logic [31:0] frequency;
    logic [7:0]  mode;
    logic [7:0]  squelch;
  } radio_out_t;

  // ports, all inputs known from time zero
  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i              = CMD_BYTE;
  logic [7:0]  rx_byte_i          = 8'd0;
  logic [31:0] preset_frequency_i = 32'd0;
  logic [7:0]  preset_mode_i      = 8'd0;
  logic [7:0]  preset_squelch_i   = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i        = 1'b0;
  logic        out_kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic [1:0]  change_code_o;
  logic [31:0] cur_frequency_o;
  logic [7:0]  cur_mode_o;
  logic [7:0]  cur_squelch_o;
  logic        psel               = 1'b0;
  logic        penable            = 1'b0;
  logic        pwrite             = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [31:0] pwdata             = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  civ_frame_radio_responder #(
    .FRAME_DEPTH(DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .rx_byte_i          (rx_byte_i),
    .preset_frequency_i (preset_frequency_i),
    .preset_mode_i      (preset_mode_i),
    .preset_squelch_i   (preset_squelch_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_kind_o         (out_kind_o),
    .tx_byte_o          (tx_byte_o),
    .last_o             (last_o),
    .change_code_o      (change_code_o),
    .cur_frequency_o    (cur_frequency_o),
    .cur_mode_o         (cur_mode_o),
    .cur_squelch_o      (cur_squelch_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // -------------------------------------------------------------------------
  // bench-side copy of the responder state
  // -------------------------------------------------------------------------
  codes_t      codes;
  logic [7:0]  frame_copy [DEPTH];
  int unsigned fill_now;
  logic [31:0] freq_now;
  logic [7:0]  mode_now;
  logic [7:0]  squelch_now;
  logic        freq_flag;
  logic        mode_flag;
  logic        squelch_flag;

  radio_out_t  owed_q [$];      // responses still to come, oldest first
  radio_item_t pending_q [$];   // items not yet put on the input port
  radio_item_t in_flight;       // item currently offered

  int unsigned queued_n    = 0;
  int unsigned counted_n   = 0;  // items that do something, for phase length
  int unsigned accepted_n  = 0;
  int unsigned fail_count  = 0;
  int unsigned cycles      = 0;

  // idle rates in percent, changed only between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // long output hold-off, armed once
  logic        hold_go   = 1'b0;
  logic        hold_used = 1'b0;
  int unsigned hold_left = 0;

  function automatic void owe_byte(input logic [7:0] b, input logic is_last);
    radio_out_t r;
    r = '0;
    r.kind    = KIND_BYTE;
    r.tx_byte = b;
    r.last    = is_last;
    owed_q.push_back(r);
  endfunction

  function automatic void owe_header(input logic [7:0] code);
    owe_byte(PREAMBLE, 1'b0);
    owe_byte(PREAMBLE, 1'b0);
    owe_byte(frame_copy[POS_TO_ADDR], 1'b0);
    owe_byte(frame_copy[POS_FROM_ADDR], 1'b0);
    owe_byte(code, 1'b0);
  endfunction

  // finished frame: code at offset 4, data from offset 5 on
  function automatic void act_on_frame();
    int unsigned dlen;
    logic [7:0]  code;
    logic [31:0] f;
    logic [7:0]  d;
    logic [7:0]  digits [5];
    int          i;
    dlen = fill_now - 6;
    code = frame_copy[POS_CODE];
    // first matching code wins
    if (code == codes.set_freq) begin
      if (dlen >= 5) begin
        // data byte 4 is most significant; low nibble is the tens digit
        f = 32'd0;
        for (i = 4; i >= 0; i--) begin
          d = frame_copy[POS_DATA + i];
          f = f * 32'd100 + 32'(d[3:0]) * 32'd10 + 32'(d[7:4]);
        end
        freq_now  = f;
        freq_flag = 1'b1;
      end
    end else if (code == codes.get_freq) begin
      // reply digits: first byte most significant, tens in high nibble
      f = freq_now;
      for (i = 4; i >= 0; i--) begin
        digits[i] = {4'((f / 32'd10) % 32'd10), 4'(f % 32'd10)};
        f = f / 32'd100;
      end
      owe_header(codes.get_freq);
      for (i = 0; i < 5; i++) owe_byte(digits[i], 1'b0);
      owe_byte(TERMINATOR, 1'b1);
    end else if (code == codes.set_squelch) begin
      if (dlen > 0) begin
        squelch_now  = frame_copy[POS_DATA];
        squelch_flag = 1'b1;
      end
    end else if (code == codes.get_squelch) begin
      owe_header(codes.get_squelch);
      owe_byte(squelch_now, 1'b0);
      owe_byte(TERMINATOR, 1'b1);
    end else if (code == codes.set_mode) begin
      if (dlen > 0) begin
        mode_now  = frame_copy[POS_DATA];
        mode_flag = 1'b1;
      end
    end
  endfunction

  function automatic void take_rx_byte(input logic [7:0] b);
    // bytes past a full store are dropped but still seen as terminator
    if (fill_now < DEPTH) begin
      frame_copy[fill_now] = b;
      fill_now++;
    end
    // preamble pair restarts the frame
    if (fill_now >= 2 && frame_copy[fill_now - 2] == PREAMBLE &&
        frame_copy[fill_now - 1] == PREAMBLE) begin
      frame_copy[0] = PREAMBLE;
      frame_copy[1] = PREAMBLE;
      fill_now = 2;
    end
    if (b == TERMINATOR) begin
      if (fill_now >= 6) act_on_frame();
      fill_now = 0;
    end
  endfunction

  // responses owed for one accepted item
  function automatic void radio_respond(input radio_item_t it);
    radio_out_t r;
    case (it.cmd)
      CMD_BYTE: take_rx_byte(it.rx_byte);
      CMD_POLL: begin
        r = '0;
        r.kind = KIND_POLL;
        r.last = 1'b1;
        // one flag cleared per poll, frequency first
        if (freq_flag) begin
          freq_flag     = 1'b0;
          r.change_code = CHG_FREQ;
        end else if (mode_flag) begin
          mode_flag     = 1'b0;
          r.change_code = CHG_MODE;
        end else if (squelch_flag) begin
          squelch_flag  = 1'b0;
          r.change_code = CHG_SQUELCH;
        end else begin
          r.change_code = CHG_NONE;
        end
        r.frequency = freq_now;
        r.mode      = mode_now;
        r.squelch   = squelch_now;
        owed_q.push_back(r);
      end
      CMD_PRESET: begin
        // flags untouched, no response
        freq_now    = it.preset_frequency;
        mode_now    = it.preset_mode;
        squelch_now = it.preset_squelch;
      end
      default: ;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // clock and cycle budget
  // -------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t: timeout, %0d responses still owed", $time, owed_q.size());
      $display("FAIL civ_frame_radio_responder");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // input driver: predicts on every input transfer, then offers the next
  // pending item unless it idles this cycle; payload holds while stalled
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        radio_respond(in_flight);
        accepted_n++;
      end
      // port is free once the offered item moved or nothing was offered
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_flight           = pending_q.pop_front();
          cmd_i              <= in_flight.cmd;
          rx_byte_i          <= in_flight.rx_byte;
          preset_frequency_i <= in_flight.preset_frequency;
          preset_mode_i      <= in_flight.preset_mode;
          preset_squelch_i   <= in_flight.preset_squelch;
          in_valid_i         <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // output monitor: checks each result transfer against the oldest owed
  // response, then picks the stall for the next cycle
  // -------------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result();
    radio_out_t want;
    if (owed_q.size() == 0) begin
      $display("%0t: unexpected result, kind %0d tx %02h last %0d change %0d",
               $time, out_kind_o, tx_byte_o, last_o, change_code_o);
      fail_count++;
    end else begin
      want = owed_q.pop_front();
      compare_field("out_kind", 32'(want.kind), 32'(out_kind_o));
      compare_field("tx_byte", 32'(want.tx_byte), 32'(tx_byte_o));
      compare_field("last", 32'(want.last), 32'(last_o));
      compare_field("change_code", 32'(want.change_code), 32'(change_code_o));
      compare_field("cur_frequency", want.frequency, cur_frequency_o);
      compare_field("cur_mode", 32'(want.mode), 32'(cur_mode_o));
      compare_field("cur_squelch", 32'(want.squelch), 32'(cur_squelch_o));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // long hold-off counter, own process
  always @(posedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------
  function automatic radio_item_t make_item(input logic [1:0] cmd);
    radio_item_t it;
    // fields the command does not use still toggle
    it.cmd              = cmd;
    it.rx_byte          = 8'($urandom);
    it.preset_frequency = $urandom;
    it.preset_mode      = 8'($urandom);
    it.preset_squelch   = 8'($urandom);
    return it;
  endfunction

  function automatic void offer(input radio_item_t it);
    pending_q.push_back(it);
    queued_n++;
    if (it.cmd != CMD_SPARE) counted_n++;
  endfunction

  function automatic void offer_byte(input logic [7:0] b);
    radio_item_t it;
    it         = make_item(CMD_BYTE);
    it.rx_byte = b;
    offer(it);
  endfunction

  function automatic void offer_preset(input logic [31:0] f, input logic [7:0] m,
                                       input logic [7:0] s);
    radio_item_t it;
    it                  = make_item(CMD_PRESET);
    it.preset_frequency = f;
    it.preset_mode      = m;
    it.preset_squelch   = s;
    offer(it);
  endfunction

  // mostly ordinary bytes, now and then preamble or terminator
  function automatic logic [7:0] frame_filler();
    if ($urandom_range(0, 15) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 8'hFC));
  endfunction

  function automatic logic [7:0] bcd_pair();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // one frame with random header and data; code mostly a live one
  function automatic void queue_frame(input int unsigned shape);
    int unsigned sel;
    int unsigned n_data;
    int unsigned i;
    logic [7:0]  code;
    sel = $urandom_range(0, 5);
    case (sel)
      0:       code = codes.set_freq;
      1:       code = codes.get_freq;
      2:       code = codes.set_squelch;
      3:       code = codes.get_squelch;
      4:       code = codes.set_mode;
      default: code = 8'($urandom);
    endcase
    // mostly the right data length, sometimes too short or too long
    case (sel)
      0:       n_data = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 5;
      1, 3:    n_data = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 0;
      2, 4:    n_data = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 1;
      default: n_data = $urandom_range(0, 5);
    endcase
    if (shape == SHAPE_OVERFLOW) n_data = $urandom_range(27, 40);
    if ($urandom_range(0, 7) == 0) offer_byte(frame_filler());
    // occasionally no preamble at all
    if ($urandom_range(0, 9) != 0) begin
      offer_byte(PREAMBLE);
      offer_byte(PREAMBLE);
    end
    offer_byte(frame_filler());
    offer_byte(frame_filler());
    offer_byte(code);
    for (i = 0; i < n_data; i++)
      offer_byte((sel == 0 && $urandom_range(0, 3) != 0) ? bcd_pair() : frame_filler());
    if (shape != SHAPE_TRUNCATED) offer_byte(TERMINATOR);
  endfunction

  function automatic void random_phase(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    logic [31:0] f;
    start = counted_n;
    while (counted_n - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_frame(SHAPE_WHOLE);
      end else if (pick < 70) begin
        offer(make_item(CMD_POLL));
      end else if (pick < 78) begin
        case ($urandom_range(0, 3))
          0:       f = 32'd0;
          1:       f = 32'hFFFF_FFFF;
          default: f = $urandom;
        endcase
        offer_preset(f, 8'($urandom), 8'($urandom));
      end else if (pick < 82) begin
        offer(make_item(CMD_SPARE));
      end else if (pick < 92) begin
        // loose bytes, preamble and terminator likely
        n = $urandom_range(1, 4);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0:       offer_byte(PREAMBLE);
            1:       offer_byte(TERMINATOR);
            default: offer_byte(8'($urandom));
          endcase
        end
      end else if (pick < 97) begin
        queue_frame(SHAPE_TRUNCATED);
      end else begin
        queue_frame(SHAPE_OVERFLOW);
      end
    end
  endfunction

  // register write through the config port, mirrored in the bench copy
  task automatic write_code(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SET_FREQ:    codes.set_freq    = val;
      REG_GET_FREQ:    codes.get_freq    = val;
      REG_SET_SQUELCH: codes.set_squelch = val;
      REG_GET_SQUELCH: codes.get_squelch = val;
      REG_SET_MODE:    codes.set_mode    = val;
      default: ;
    endcase
  endtask

  task automatic write_all_codes(input logic [7:0] sf, input logic [7:0] gf,
                                 input logic [7:0] ss, input logic [7:0] gs,
                                 input logic [7:0] sm);
    write_code(REG_SET_FREQ, sf);
    write_code(REG_GET_FREQ, gf);
    write_code(REG_SET_SQUELCH, ss);
    write_code(REG_GET_SQUELCH, gs);
    write_code(REG_SET_MODE, sm);
  endtask

  // all items taken, all responses in, then let a set frequency finish
  task automatic settle();
    int unsigned waited;
    while (accepted_n != queued_n) @(posedge clk_i);
    waited = 0;
    while (owed_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (owed_q.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, owed_q.size());
      fail_count++;
      owed_q.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    // state after reset
    codes.set_freq    = SET_FREQ_RESET;
    codes.get_freq    = GET_FREQ_RESET;
    codes.set_squelch = SET_SQUELCH_RESET;
    codes.get_squelch = GET_SQUELCH_RESET;
    codes.set_mode    = SET_MODE_RESET;
    fill_now     = 0;
    freq_now     = FREQ_RESET;
    mode_now     = MODE_RESET;
    squelch_now  = SQUELCH_RESET;
    freq_flag    = 1'b0;
    mode_flag    = 1'b0;
    squelch_flag = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase 0: reset codes, sender idles rarely, receiver often
    send_idle_pct = 7;
    recv_idle_pct = 62;

    // directed: ignored command, extreme preset, lone terminator,
    // junk then preamble restart into a get frequency of the largest word,
    // set frequency with all nibbles at 15 (wraps), then two polls
    offer(make_item(CMD_SPARE));
    offer_preset(32'hFFFF_FFFF, 8'h00, 8'hFF);
    offer_byte(TERMINATOR);
    offer_byte(8'h77);
    offer_byte(PREAMBLE);
    offer_byte(PREAMBLE);
    offer_byte(8'h00);
    offer_byte(8'hFF);
    offer_byte(codes.get_freq);
    offer_byte(TERMINATOR);
    offer_byte(PREAMBLE);
    offer_byte(PREAMBLE);
    offer_byte(8'hE0);
    offer_byte(8'h11);
    offer_byte(codes.set_freq);
    repeat (5) offer_byte(8'hFF);
    offer_byte(TERMINATOR);
    offer(make_item(CMD_POLL));
    offer(make_item(CMD_POLL));
    random_phase(PHASE_ITEMS);
    settle();

    // phase 1: codes at the extremes, idle pattern reversed
    write_all_codes(8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01);
    send_idle_pct = 62;
    recv_idle_pct = 7;
    random_phase(PHASE_ITEMS);
    settle();

    // phase 2: overlapping codes, no idling, long output hold-off so the
    // block backs up while the sender keeps offering
    write_all_codes(8'hFF, 8'hFF, 8'h00, 8'h42, 8'h00);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(PHASE_ITEMS);
    @(posedge clk_i);
    hold_go <= 1'b1;
    settle();

    // phase 3: back to the reset codes, no idling
    write_all_codes(SET_FREQ_RESET, GET_FREQ_RESET, SET_SQUELCH_RESET,
                    GET_SQUELCH_RESET, SET_MODE_RESET);
    random_phase(PHASE_ITEMS);
    settle();

    if (fail_count == 0) begin
      $display("PASS civ_frame_radio_responder");
    end else begin
      $display("FAIL civ_frame_radio_responder");
    end
    $finish;
  end

endmodule

`default_nettype wire
